@@ rtl/core/trie_pkg.sv @@
// ----------------------------------------------------------------------------
// Trie package
// Shared types, sizes, action codes and the slot address helper for the
// 26-way prefix trie.
// ----------------------------------------------------------------------------
package trie_pkg;

  // Pool and alphabet sizes.
  localparam int NODE_COUNT  = 1024;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int FREE_W      = $clog2(NODE_COUNT + 1);
  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
  localparam int SLOT_W      = $clog2(CHILD_DEPTH);
  localparam int LETTER_W    = 5;
  localparam int ACTION_W    = 2;

  // Action codes. Any code other than insert and search acts as a prefix query.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd2;

  // One input item: one letter of a word.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } item_t;

  // One result item, given on the last letter of a word.
  typedef struct packed {
    logic found;
    logic out_of_nodes;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_MARK,
    ST_REPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic walk;
    logic mark;
    logic reply;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic last;
    logic search;
  } dp_status_t;

  // Flat address of one child link: node * ALPHABET + letter.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                input logic [LETTER_W-1:0] letter);
    slot_of = SLOT_W'(node) * SLOT_W'(ALPHABET) + SLOT_W'(letter);
  endfunction

endpackage

@@ rtl/core/trie_insert_and_lookup_top.sv @@
// ----------------------------------------------------------------------------
// Trie insert and lookup, top level
// A 26-way prefix trie fed one letter per item: insert, exact search and
// prefix query, with one result item on the last letter of each word.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------
//   input     start, busy          item   (action, letter, last)
//   result    done (one cycle)     result (found, out_of_nodes)
//
// A letter that is not the last of its word is handled by a read of its child
// link from the link memory, then a step that follows or allocates it. The last
// letter adds a step for the end mark, and a search one more for the end mark
// read.
// After reset a clearing pass zeroes the link memory, one entry per cycle, and
// the end mark memory, with busy high. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
module trie_insert_and_lookup_top
  import trie_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  trie_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  trie_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

  // At most one command is active in any cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.capture, cmd.walk, cmd.mark, cmd.reply}))
    else $error("more than one controller command active");

  // An accepted item is walked in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> cmd.walk)
    else $error("accepted item not walked");

  // A result only follows a mark or reply step.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(cmd.mark) || $past(cmd.reply)))
    else $error("result without a finishing step");

  // A result never reports both found and pool exhaustion.
  assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.out_of_nodes))
    else $error("found and out_of_nodes both set");

endmodule

@@ rtl/core/trie_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/trie_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trie controller
// Sequences the clearing pass and the walk, mark and reply steps of each item.
// ----------------------------------------------------------------------------
module trie_ctrl
  import trie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register; reset begins the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        state_next = status.last ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        cmd.mark   = 1'b1;
        state_next = status.search ? ST_REPLY : ST_IDLE;
      end
      ST_REPLY: begin
        cmd.reply  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/trie_dp.sv @@
// ----------------------------------------------------------------------------
// Trie datapath
// Holds the child link and end mark memories, the cursor, the miss flag, the
// free-node counter and the clearing counter, and forms each result item.
// ----------------------------------------------------------------------------
module trie_dp
  import trie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       done,
  output result_t    result
);

  // Captured item fields and the slot it addresses.
  logic [ACTION_W-1:0] act_q;
  logic [LETTER_W-1:0] letter_q;
  logic                last_q;
  logic [SLOT_W-1:0]   slot_q;

  // Walk state.
  logic [NODE_W-1:0]   cursor;
  logic                miss;
  logic [FREE_W-1:0]   free_count;
  logic [SLOT_W-1:0]   clr_cnt;

  // Memory ports.
  logic                child_we;
  logic [SLOT_W-1:0]   child_waddr;
  logic [NODE_W-1:0]   child_wdata;
  logic [NODE_W-1:0]   child_rdata;
  logic                mark_we;
  logic [NODE_W-1:0]   mark_waddr;
  logic                mark_wdata;
  logic                mark_rdata;

  // Walk decisions.
  logic letter_ok;
  logic active;
  logic hit;
  logic can_alloc;
  logic alloc;
  logic is_insert;
  logic is_search;

  assign is_insert = (act_q == ACT_INSERT);
  assign is_search = (act_q == ACT_SEARCH);
  assign letter_ok = (32'(letter_q) < 32'(ALPHABET));
  assign active    = !miss && letter_ok;
  assign hit       = (child_rdata != '0);
  assign can_alloc = is_insert && (free_count < FREE_W'(NODE_COUNT));
  assign alloc     = cmd.walk && active && !hit && can_alloc;

  assign status.clear_done = (clr_cnt == SLOT_W'(CHILD_DEPTH - 1));
  assign status.last       = last_q;
  assign status.search     = is_search;

  // Capture the item; the link read for it is issued in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= item.action;
      letter_q <= item.letter;
      last_q   <= item.last;
      slot_q   <= slot_of(cursor, item.letter);
    end
  end

  // Clearing counter for the pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !status.clear_done) begin
      clr_cnt <= clr_cnt + SLOT_W'(1);
    end
  end

  // Cursor, miss flag and free-node counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      miss       <= 1'b0;
      free_count <= FREE_W'(1);
    end else if (cmd.walk && active) begin
      if (hit) begin
        cursor <= child_rdata;
      end else if (can_alloc) begin
        cursor     <= free_count[NODE_W-1:0];
        free_count <= free_count + FREE_W'(1);
      end else begin
        miss <= 1'b1;
      end
    end else if ((cmd.mark && !is_search) || cmd.reply) begin
      // The word ends: restart at the root.
      cursor <= '0;
      miss   <= 1'b0;
    end
  end

  // Child link writes: clearing pass or a new link.
  always_comb begin
    child_we    = cmd.clear || alloc;
    child_waddr = cmd.clear ? clr_cnt : slot_q;
    child_wdata = cmd.clear ? '0 : free_count[NODE_W-1:0];
  end

  // End mark writes: clearing pass, a fresh node, or the end of an insert.
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = cursor;
    mark_wdata = 1'b0;
    priority if (cmd.clear) begin
      mark_we    = (32'(clr_cnt) < 32'(NODE_COUNT));
      mark_waddr = clr_cnt[NODE_W-1:0];
    end else if (alloc) begin
      mark_we    = 1'b1;
      mark_waddr = free_count[NODE_W-1:0];
    end else if (cmd.mark && is_insert && !miss) begin
      mark_we    = 1'b1;
      mark_wdata = 1'b1;
    end
  end

  trie_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (slot_of(cursor, item.letter)),
    .rdata (child_rdata)
  );

  trie_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (cursor),
    .rdata (mark_rdata)
  );

  // Result item, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.mark && !is_search) || cmd.reply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      result.found        <= !miss;
      result.out_of_nodes <= is_insert && miss;
    end else if (cmd.reply) begin
      result.found        <= !miss && mark_rdata;
      result.out_of_nodes <= 1'b0;
    end
  end

endmodule
